// ----- src/rmh_pkg.sv -----
package rmh_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int HEAP_DEPTH = (MAX_ITEMS + 1) / 2 + 1;
    localparam int AW         = $clog2(HEAP_DEPTH);
    localparam int CW         = $clog2(MAX_ITEMS + 1);
    localparam int DW         = 32;

    typedef logic [AW-1:0] addr_t;
    typedef logic [AW:0]   hcnt_t;
    typedef logic [DW-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_WR,
        ST_UP_RD,
        ST_UP_CMP,
        ST_POP_RD,
        ST_DN_RD,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_SEL,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_OUT
    } state_t;

endpackage

// ----- src/running_median_two_heaps.sv -----
// Running median engine built around two heap memories.
// Input channel: sample (signed 32) and restart, handshake in_valid/in_stall.
// Output channel: median, item_count, full_res, handshake out_valid/out_stall.
// One result word per input word, in order.
// Each word is handled alone: a heap insert sifts up one level at a time
// (read parent, then compare and write), a rebalance pop sifts down one level
// at a time (read left child, read right child, then compare and write), then
// a push into the other heap sifts up again. The sift loops over the single
// read port of each heap RAM set the time from accept to result; a restart or
// a full drop does no sift. The next word is taken only once the engine is
// back in idle; in_stall is high while a word is being worked on. The result
// register holds until out_stall is low; a finished result waits in the
// engine, with the input stalled, while the register is still full.
// Reset (rst_n low, asynchronous) empties both heaps; the heap memories
// themselves are not cleared and need no sweep.
module running_median_two_heaps (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  sample,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  median,
    output logic [10:0]         item_count,
    output logic                full_res
);
    import rmh_pkg::*;

    word_t mem_lo [HEAP_DEPTH];
    word_t mem_hi [HEAP_DEPTH];

    state_t state_reg, state_next;
    hcnt_t  lcnt_reg, lcnt_next, ucnt_reg, ucnt_next;
    logic   heap_reg, heap_next;      // 1: lower (max) heap
    logic   phase_reg, phase_next;    // 0: first push, 1: rebalance push
    addr_t  idx_reg, idx_next;
    addr_t  best_reg, best_next;
    word_t  val_reg, val_next;        // value being sifted
    word_t  bval_reg, bval_next;
    hcnt_t  n_reg, n_next;
    logic   full_reg, full_next;
    word_t  med_reg, med_next;
    logic   ov_reg, ov_next;

    // result register
    word_t       omed_reg, omed_next;
    logic [10:0] ocnt_reg, ocnt_next;
    logic        ofull_reg, ofull_next;

    // single memory port per heap, muxed by heap_reg
    logic   rd_en, wr_en;
    addr_t  rd_addr, wr_addr;
    word_t  wr_data;
    word_t  rd_lo_reg, rd_hi_reg, rdata;

    always_ff @(posedge clk)
    begin
        if (wr_en && heap_reg)
        begin
            mem_lo[wr_addr] <= wr_data;
        end
        if (wr_en && !heap_reg)
        begin
            mem_hi[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_lo_reg <= mem_lo[rd_addr];
            rd_hi_reg <= mem_hi[rd_addr];
        end
    end

    assign rdata = heap_reg ? rd_lo_reg : rd_hi_reg;

    function automatic logic above(input word_t a, input word_t b, input logic is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    logic  in_acc;
    word_t vin;
    hcnt_t hcnt;
    addr_t parent;
    logic  [AW+1:0] lch;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign vin    = sample ^ 32'h8000_0000;
    assign hcnt   = heap_reg ? lcnt_reg : ucnt_reg;
    assign parent = AW'((idx_reg - 1'b1) >> 1);
    assign lch    = {1'b0, idx_reg, 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lcnt_reg  <= '0;
            ucnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lcnt_reg  <= lcnt_next;
            ucnt_reg  <= ucnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        heap_reg  <= heap_next;
        phase_reg <= phase_next;
        idx_reg   <= idx_next;
        best_reg  <= best_next;
        val_reg   <= val_next;
        bval_reg  <= bval_next;
        n_reg     <= n_next;
        full_reg  <= full_next;
        med_reg   <= med_next;
        omed_reg  <= omed_next;
        ocnt_reg  <= ocnt_next;
        ofull_reg <= ofull_next;
    end

    always_comb
    begin
        state_next = state_reg;
        lcnt_next  = lcnt_reg;
        ucnt_next  = ucnt_reg;
        heap_next  = heap_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        val_next   = val_reg;
        bval_next  = bval_reg;
        n_next     = n_reg;
        full_next  = full_reg;
        med_next   = med_reg;
        omed_next  = omed_reg;
        ocnt_next  = ocnt_reg;
        ofull_next = ofull_reg;
        ov_next    = ov_reg && out_stall;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    full_next = 1'b0;
                    if (restart)
                    begin
                        lcnt_next  = '0;
                        ucnt_next  = '0;
                        state_next = ST_TOP_RD;
                    end
                    else if (CW'(lcnt_reg) + CW'(ucnt_reg) >= CW'(MAX_ITEMS))
                    begin
                        full_next  = 1'b1;
                        state_next = ST_TOP_RD;
                    end
                    else
                    begin
                        // lower top is med_reg (flipped back) when lower nonempty
                        val_next   = vin;
                        phase_next = 1'b0;
                        heap_next  = (lcnt_reg == '0) || (vin <= (med_reg ^ 32'h8000_0000));
                        state_next = ST_PUSH_WR;
                    end
                end
            end
            ST_PUSH_WR:
            begin
                if (hcnt >= hcnt_t'(HEAP_DEPTH))
                begin
                    state_next = ST_SEL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(hcnt);
                    idx_next = AW'(hcnt);
                    if (heap_reg) lcnt_next = lcnt_reg + 1'b1;
                    else          ucnt_next = ucnt_reg + 1'b1;
                    state_next = (hcnt == '0) ? ST_SEL : ST_UP_RD;
                end
            end
            ST_UP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = parent;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                if (above(val_reg, rdata, heap_reg))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = rdata;
                    idx_next = parent;
                    state_next = (parent == '0) ? ST_POP_RD : ST_UP_RD;
                end
                else
                begin
                    wr_en = 1'b1;
                    state_next = ST_SEL;
                end
                // parent reached root: write value there
                if (above(val_reg, rdata, heap_reg) && parent == '0)
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:
            begin
                // finish sift-up at root
                wr_en      = 1'b1;
                wr_addr    = '0;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (!phase_reg && (lcnt_reg > ucnt_reg + 1'b1))
                begin
                    heap_next  = 1'b1;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    lcnt_next  = lcnt_reg - 1'b1;
                    n_next     = lcnt_reg - 1'b1;
                    state_next = ST_DN_RD;
                end
                else if (!phase_reg && (ucnt_reg > lcnt_reg))
                begin
                    heap_next  = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    ucnt_next  = ucnt_reg - 1'b1;
                    n_next     = ucnt_reg - 1'b1;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_TOP_RD;
                end
            end
            ST_DN_RD:
            begin
                // rdata = old top; fetch last element
                bval_next  = rdata;
                rd_en      = 1'b1;
                rd_addr    = AW'(n_reg);
                idx_next   = '0;
                state_next = ST_DN_L;
            end
            ST_DN_L:
            begin
                // first entry: rdata is the moved last element
                val_next   = rdata;
                state_next = ST_DN_R;
                if (hcnt_t'(lch) < n_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lch);
                end
                else
                begin
                    state_next = ST_DN_CMP;
                    best_next  = idx_reg;
                end
            end
            ST_DN_R:
            begin
                // rdata = left child
                best_next = idx_reg;
                med_next  = val_reg;   // temp: best value
                if (above(rdata, val_reg, heap_reg))
                begin
                    best_next = AW'(lch);
                    med_next  = rdata;
                end
                if (hcnt_t'(lch) + 1'b1 < n_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lch + 1'b1);
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (hcnt_t'(lch) + 1'b1 < n_reg && above(rdata, med_reg, heap_reg)
                    && hcnt_t'(lch) < n_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = rdata;
                    idx_next = AW'(lch + 1'b1);
                    state_next = ST_TOP_WAIT;
                end
                else if (hcnt_t'(lch) < n_reg && best_reg != idx_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = med_reg;
                    idx_next = best_reg;
                    state_next = ST_TOP_WAIT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = val_reg;
                    // push popped top into other heap
                    val_next   = bval_reg;
                    heap_next  = !heap_reg;
                    phase_next = 1'b1;
                    state_next = ST_PUSH_WR;
                end
            end
            ST_TOP_WAIT:
            begin
                // continue sift-down at new index; val_reg still the moving value
                state_next = ST_DN_L;
                if (hcnt_t'(lch) < n_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(lch);
                    state_next = ST_DN_R;
                end
                else
                begin
                    best_next  = idx_reg;
                    state_next = ST_DN_CMP;
                end
            end
            ST_TOP_RD:
            begin
                heap_next  = 1'b1;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait here while the previous word is still held
                if (!ov_reg || !out_stall)
                begin
                    med_next   = (lcnt_reg == '0) ? '0 : (rd_lo_reg ^ 32'h8000_0000);
                    omed_next  = (lcnt_reg == '0) ? '0 : (rd_lo_reg ^ 32'h8000_0000);
                    ocnt_next  = 11'(CW'(lcnt_reg) + CW'(ucnt_reg));
                    ofull_next = full_reg;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = ov_reg;
    assign median     = omed_reg;
    assign item_count = ocnt_reg;
    assign full_res   = ofull_reg;

`ifndef SYNTHESIS
    a_cnt_bal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (lcnt_reg == ucnt_reg || lcnt_reg == ucnt_reg + 1'b1))
        else $error("heap counts out of balance");
    a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> out_valid)
        else $error("result not presented");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(lcnt_reg) + CW'(ucnt_reg)) <= CW'(MAX_ITEMS))
        else $error("capacity exceeded");
`endif

endmodule
